// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Sizes and state type of the linear probing hash set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lphs_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int COUNT_OUT_W = 11;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } lphs_state_t;

endpackage

// ===== rtl/linear_probe_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Open-addressing set of 64-bit keys with linear probing over one table RAM.
// ----------------------------------------------------------------------------
// After reset the core clears every slot of its table and holds busy high
// meanwhile. A word is taken when start is high and busy is low. The table
// has one write and one read port and gives one slot read per cycle, so each
// word reads its home slot and then the following slots in turn, wrapping
// around, until a hit, an empty slot or a full sweep resolves it. The
// result appears for exactly one cycle with done high, in the cycle busy drops;
// it cannot be held off, so capture it then. A new start may land in that cycle.
// An insert that sweeps all slots without a hit or an empty slot reports
// table_full and changes nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_probe_hash_set_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  action,
    input  logic [lphs_pkg::KEY_W-1:0]            key,
    output logic                                  done,
    output logic                                  found,
    output logic                                  added,
    output logic                                  table_full,
    output logic [lphs_pkg::COUNT_OUT_W-1:0]      stored_count
);

    localparam int IDX_W = lphs_pkg::IDX_W;
    localparam int KEY_W = lphs_pkg::KEY_W;
    localparam int CNT_W = lphs_pkg::CNT_W;
    localparam int OUT_W = lphs_pkg::COUNT_OUT_W;

    lphs_pkg::lphs_state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] visited_reg, visited_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;

    logic [KEY_W-1:0] key_reg, key_next;
    logic             insert_reg, insert_next;
    logic             found_reg, found_next;
    logic             added_reg, added_next;
    logic             full_reg, full_next;

    logic [KEY_W-1:0] key_eff;
    logic [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;

    logic [KEY_W-1:0] slot_mem [lphs_pkg::TABLE_SLOTS];

    // zero marks an empty slot, so key 0 is kept as 1
    assign key_eff = (key == '0) ? KEY_W'(1) : key;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        pos_next     = pos_reg;
        visited_next = visited_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        key_next     = key_reg;
        insert_next  = insert_reg;
        found_next   = found_reg;
        added_next   = added_reg;
        full_next    = full_reg;
        rd_addr      = pos_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = key_reg;

        case (state_reg)
            lphs_pkg::ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = lphs_pkg::ST_IDLE;
                end
            end
            lphs_pkg::ST_IDLE:
            begin
                rd_addr = key_eff[IDX_W-1:0];
                if (start)
                begin
                    key_next     = key_eff;
                    insert_next  = action;
                    pos_next     = key_eff[IDX_W-1:0];
                    visited_next = '0;
                    state_next   = lphs_pkg::ST_CHECK;
                end
            end
            lphs_pkg::ST_CHECK:
            begin
                if (rd_data_reg == '0)
                begin
                    // empty slot: key absent
                    wr_en      = insert_reg;
                    found_next = 1'b0;
                    added_next = insert_reg;
                    full_next  = 1'b0;
                    if (insert_reg)
                    begin
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    done_next  = 1'b1;
                    state_next = lphs_pkg::ST_IDLE;
                end
                else if (rd_data_reg == key_reg)
                begin
                    found_next = 1'b1;
                    added_next = 1'b0;
                    full_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = lphs_pkg::ST_IDLE;
                end
                else if (visited_reg == '1)
                begin
                    // full sweep done
                    found_next = 1'b0;
                    added_next = 1'b0;
                    full_next  = insert_reg;
                    done_next  = 1'b1;
                    state_next = lphs_pkg::ST_IDLE;
                end
                else
                begin
                    rd_addr      = pos_reg + 1'b1;
                    pos_next     = pos_reg + 1'b1;
                    visited_next = visited_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lphs_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lphs_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            pos_reg     <= '0;
            visited_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            pos_reg     <= pos_next;
            visited_reg <= visited_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        insert_reg <= insert_next;
        found_reg  <= found_next;
        added_reg  <= added_next;
        full_reg   <= full_next;
    end

    assign busy         = (state_reg != lphs_pkg::ST_IDLE);
    assign done         = done_reg;
    assign found        = found_reg;
    assign added        = added_reg;
    assign table_full   = full_reg;
    assign stored_count = OUT_W'(count_reg);

    `ASSERT_IMPLY(a_done_after_check, clk, rst_n, done_reg, $past(state_reg == lphs_pkg::ST_CHECK))
    `ASSERT_IMPLY(a_one_outcome, clk, rst_n, done_reg, $onehot0({found_reg, added_reg, full_reg}))
    `ASSERT_IMPLY(a_count_step, clk, rst_n, done_reg && added_reg, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= CNT_W'(lphs_pkg::TABLE_SLOTS))

endmodule

// ===== sim/lphs_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_tb_pkg
// Shared testbench types for the hash set: word actions, which the stimulus
// side and the reply checker both use, and the reply layout of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lphs_tb_pkg;

    import lphs_pkg::*;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } set_action_t;

    typedef struct packed {
        logic                   found;
        logic                   added;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] stored_count;
    } set_reply_t;

endpackage

// ===== sim/lphs_reply_checker.sv =====
// ----------------------------------------------------------------------------
// lphs_reply_checker
// Watches the word and reply ports of the hash set, keeps its own copy of the
// probe table, predicts the reply of every accepted word and compares each
// reply against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lphs_reply_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              action,
    input  logic [lphs_pkg::KEY_W-1:0]        key,
    input  logic                              done,
    input  logic                              found,
    input  logic                              added,
    input  logic                              table_full,
    input  logic [lphs_pkg::COUNT_OUT_W-1:0]  stored_count,
    output int                                failures,
    output int                                pending
);

    import lphs_pkg::*;
    import lphs_tb_pkg::*;

    bit [KEY_W-1:0] slot_copy [TABLE_SLOTS];
    int unsigned    keys_held;
    set_reply_t     replies_due [$];

    function automatic set_reply_t probe_set(input set_action_t act,
                                             input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int unsigned      pos;
        int unsigned      hops;
        logic             hit;
        logic             hole;
        set_reply_t       reply;
        k    = (raw == '0) ? KEY_W'(1) : raw;
        pos  = 32'(k[IDX_W-1:0]);
        hops = 0;
        hit  = 1'b0;
        hole = 1'b0;
        while (hops < TABLE_SLOTS && !hit && !hole)
        begin
            if (slot_copy[pos] == '0)
                hole = 1'b1;
            else if (slot_copy[pos] == k)
                hit = 1'b1;
            else
            begin
                pos  = (pos + 1) % TABLE_SLOTS;
                hops = hops + 1;
            end
        end
        reply.found      = hit;
        reply.added      = (act == ACT_INSERT) && hole;
        reply.table_full = (act == ACT_INSERT) && !hit && !hole;
        if (reply.added)
        begin
            slot_copy[pos] = k;
            keys_held      = keys_held + 1;
        end
        reply.stored_count = keys_held[COUNT_OUT_W-1:0];
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_reply_t want;
        if (!rst_n)
        begin
            foreach (slot_copy[i])
                slot_copy[i] = '0;
            keys_held = 0;
            replies_due.delete();
            failures = 0;
        end
        else
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: reply with none expected: found=%0b added=%0b",
                             $time, found, added);
                    $display("%0t:   table_full=%0b stored_count=%0d",
                             $time, table_full, stored_count);
                    failures++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if ({found, added, table_full, stored_count} !== want)
                    begin
                        $display("%0t: reply mismatch: expected found=%0b added=%0b",
                                 $time, want.found, want.added);
                        $display("%0t:   expected table_full=%0b stored_count=%0d",
                                 $time, want.table_full, want.stored_count);
                        $display("%0t:   actual found=%0b added=%0b",
                                 $time, found, added);
                        $display("%0t:   actual table_full=%0b stored_count=%0d",
                                 $time, table_full, stored_count);
                        failures++;
                    end
                end
            end
            if (start && !busy)
                replies_due.push_back(probe_set(set_action_t'(action), key));
        end
        pending = replies_due.size();
    end

endmodule

// ===== sim/tb_linear_probe_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_set_core
// Drives lookup and insert words into the hash set: directed corner keys, a
// random mix with clustered homes and repeated keys, a fill up to a full table
// and a stretch of full-table traffic. The reply checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_hash_set_core;

    import lphs_pkg::*;
    import lphs_tb_pkg::*;

    localparam int               RUN_LIMIT    = 8_000_000;
    localparam int               RANDOM_WORDS = 900;
    localparam int               FULL_WORDS   = 40;
    localparam logic [KEY_W-1:0] HOME_LAST    = KEY_W'(TABLE_SLOTS - 1);
    localparam logic [KEY_W-1:0] TOP_BIT      = {1'b1, {(KEY_W-1){1'b0}}};

    logic                   clk    = 1'b0;
    logic                   rst_n  = 1'b0;
    logic                   start  = 1'b0;
    logic                   action = ACT_LOOKUP;
    logic [KEY_W-1:0]       key    = '0;
    logic                   busy;
    logic                   done;
    logic                   found;
    logic                   added;
    logic                   table_full;
    logic [COUNT_OUT_W-1:0] stored_count;
    int                     failures;
    int                     pending;
    logic                   table_filled = 1'b0;
    int                     cycle_count  = 0;
    bit                     gaps_on      = 1'b1;
    logic [KEY_W-1:0]       key_log [$];

    always #5 clk = ~clk;

    linear_probe_hash_set_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .key          (key),
        .done         (done),
        .found        (found),
        .added        (added),
        .table_full   (table_full),
        .stored_count (stored_count)
    );

    lphs_reply_checker u_reply_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .key          (key),
        .done         (done),
        .found        (found),
        .added        (added),
        .table_full   (table_full),
        .stored_count (stored_count),
        .failures     (failures),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (done && stored_count == COUNT_OUT_W'(TABLE_SLOTS))
            table_filled <= 1'b1;
    end

    // entered and left at a falling edge
    task automatic send_word(input set_action_t act, input logic [KEY_W-1:0] k);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            start  <= 1'b0;
            action <= $urandom_range(0, 1);
            key    <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        start  <= 1'b1;
        action <= act;
        key    <= k;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    k[IDX_W-1:0] = IDX_W'(TABLE_SLOTS - 8) + IDX_W'($urandom_range(0, 15));
            2, 3:    k[IDX_W-1:0] = IDX_W'(TABLE_SLOTS / 4) + IDX_W'($urandom_range(0, 15));
            9:
            begin
                case ($urandom_range(0, 2))
                    0:       k = '0;
                    1:       k = '1;
                    default: k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                endcase
            end
            default: ;
        endcase
        return k;
    endfunction

    task automatic random_word();
        set_action_t      act;
        logic [KEY_W-1:0] k;
        act = set_action_t'($urandom_range(0, 1));
        if (key_log.size() != 0 && $urandom_range(0, 99) < 45)
            k = key_log[$urandom_range(0, key_log.size() - 1)];
        else
        begin
            k = fresh_key();
            key_log.push_back(k);
        end
        send_word(act, k);
    endtask

    initial
    begin
        logic [KEY_W-1:0] fill_key;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(ACT_LOOKUP, '0);
        send_word(ACT_INSERT, '0);
        send_word(ACT_LOOKUP, KEY_W'(1));
        send_word(ACT_INSERT, KEY_W'(1));
        send_word(ACT_LOOKUP, '0);
        send_word(ACT_INSERT, '1);
        send_word(ACT_INSERT, HOME_LAST);
        send_word(ACT_INSERT, TOP_BIT | HOME_LAST);
        send_word(ACT_LOOKUP, TOP_BIT | HOME_LAST);
        send_word(ACT_LOOKUP, (TOP_BIT >> 1) | HOME_LAST);
        send_word(ACT_INSERT, TOP_BIT);
        send_word(ACT_LOOKUP, TOP_BIT);
        send_word(ACT_INSERT, 64'h5555_5555_5555_5555);
        send_word(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(ACT_LOOKUP, 64'h5555_5555_5555_5555);
        send_word(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(ACT_LOOKUP, '1);

        for (int blk = 0; blk < RANDOM_WORDS / 100; blk++)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            repeat (100) random_word();
        end

        // one insert per home slot, in order, until the count hits the table size
        gaps_on = 1'b1;
        for (int i = 0; i < TABLE_SLOTS && !table_filled; i++)
        begin
            fill_key = {$urandom, $urandom};
            fill_key[IDX_W-1:0] = IDX_W'(i);
            key_log.push_back(fill_key);
            send_word(ACT_INSERT, fill_key);
        end

        gaps_on = 1'b0;
        send_word(ACT_INSERT, '0);
        send_word(ACT_LOOKUP, (TOP_BIT >> 2) | HOME_LAST);
        send_word(ACT_INSERT, (TOP_BIT >> 2) | HOME_LAST);
        repeat (FULL_WORDS) random_word();

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
